/* hdl/slab_free_list_allocator_core_macros.svh */
// Assertion macros used by the slab allocator checker
`ifndef SLAB_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH
`define SLAB_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication
`define SLAB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SLAB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/slab_pkg.sv */
// Types, constants and codes shared by the slab allocator modules
package slab_pkg;

    localparam int MAX_SLOTS_DEF    = 1024;
    localparam int HEADER_BYTES_DEF = 16;

    localparam int ADDR_W    = 32;
    localparam int OBJ_W     = 16;
    localparam int REGION_W  = 24;
    localparam int STRIDE_W  = 17;
    localparam int REQ_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int FREE_W    = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;
    localparam int DIV_W     = 32;

    localparam logic [OBJ_W-1:0] OBJ_BYTES_RST = OBJ_W'(64);

    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_BYTES = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BYTES = CFG_IDX_W'(2);

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_INIT  = 2'd2,
        REQ_CLEAR = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_NO_SLOT = 2'd1,
        ST_REJECT  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_A_CHECK,
        S_A_GRANT,
        S_F_CHECK,
        S_F_DIV,
        S_F_PUSH,
        S_I_START,
        S_I_DIV,
        S_I_SET,
        S_I_WALK
    } t_state;

    typedef struct packed {
        logic    take;
        logic    div_free;
        logic    div_init;
        logic    init_set;
        logic    walk;
        logic    push;
        logic    pop;
        logic    clear;
        logic    respond;
        t_status resp_status;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic free_pre_bad;
        logic div_done;
        logic free_post_bad;
        logic walk_last;
    } t_stat;

endpackage

/* hdl/slab_ctrl.sv */
// Request sequencer of the slab allocator
module slab_ctrl
    import slab_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [REQ_W-1:0] i_req_type,
    input  t_stat            i_stat,
    output t_cmd             o_cmd,
    output logic             o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (t_req'(i_req_type))
                        REQ_ALLOC: n_state = S_A_CHECK;
                        REQ_FREE:  n_state = S_F_CHECK;
                        REQ_INIT:  n_state = S_I_START;
                        REQ_CLEAR: n_state = S_CLEAR;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_CLEAR:   n_state = S_IDLE;
            S_A_CHECK: n_state = i_stat.empty ? S_IDLE : S_A_GRANT;
            S_A_GRANT: n_state = S_IDLE;
            S_F_CHECK: n_state = i_stat.free_pre_bad ? S_IDLE : S_F_DIV;
            S_F_DIV:   n_state = i_stat.div_done ? S_F_PUSH : S_F_DIV;
            S_F_PUSH:  n_state = S_IDLE;
            S_I_START: n_state = S_I_DIV;
            S_I_DIV:   n_state = i_stat.div_done ? S_I_SET : S_I_DIV;
            S_I_SET:   n_state = S_I_WALK;
            S_I_WALK:  n_state = i_stat.walk_last ? S_IDLE : S_I_WALK;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd             = '0;
        o_cmd.resp_status = ST_DONE;
        o_busy            = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                o_cmd.take = i_start;
            end
            S_CLEAR: begin
                o_cmd.clear   = 1'b1;
                o_cmd.respond = 1'b1;
            end
            S_A_CHECK: begin
                if (i_stat.empty) begin
                    o_cmd.respond     = 1'b1;
                    o_cmd.resp_status = ST_NO_SLOT;
                end
            end
            S_A_GRANT: begin
                o_cmd.pop     = 1'b1;
                o_cmd.respond = 1'b1;
            end
            S_F_CHECK: begin
                if (i_stat.free_pre_bad) begin
                    o_cmd.respond     = 1'b1;
                    o_cmd.resp_status = ST_REJECT;
                end else begin
                    o_cmd.div_free = 1'b1;
                end
            end
            S_F_PUSH: begin
                o_cmd.respond = 1'b1;
                if (i_stat.free_post_bad) begin
                    o_cmd.resp_status = ST_REJECT;
                end else begin
                    o_cmd.push = 1'b1;
                end
            end
            S_I_START: begin
                o_cmd.div_init = 1'b1;
            end
            S_I_SET: begin
                o_cmd.init_set = 1'b1;
            end
            S_I_WALK: begin
                o_cmd.walk    = 1'b1;
                o_cmd.respond = i_stat.walk_last;
            end
            default: begin
                o_cmd.take = 1'b0;
            end
        endcase
    end

endmodule

/* hdl/slab_div.sv */
// Restoring divider, one quotient bit per cycle
module slab_div
    import slab_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DIV_W-1:0]    i_dividend,
    input  logic [STRIDE_W-1:0] i_divisor,
    output logic                o_done,
    output logic [DIV_W-1:0]    o_quotient,
    output logic [STRIDE_W-1:0] o_remainder
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic                r_run;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [DIV_W-1:0]    r_q;
    logic [STRIDE_W-1:0] r_rem;
    logic [STRIDE_W-1:0] r_dsr;
    logic [STRIDE_W:0]   w_shift;
    logic [STRIDE_W:0]   w_diff;
    logic                w_ge;

    assign w_shift = {r_rem, r_q[DIV_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_dsr});
    assign w_diff  = w_shift - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_run && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(DIV_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_run) begin
            r_q   <= {r_q[DIV_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[STRIDE_W-1:0] : w_shift[STRIDE_W-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_q;
    assign o_remainder = r_rem;

endmodule

/* hdl/slab_dp.sv */
// Slab allocator datapath: registers, link memory, divider and result
module slab_dp
    import slab_pkg::*;
#(
    parameter int MAX_SLOTS    = MAX_SLOTS_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic [ADDR_W-1:0]    i_object_address,
    output logic                 o_result_valid,
    output t_status              o_status,
    output logic [ADDR_W-1:0]    o_granted_address,
    output logic [FREE_W-1:0]    o_free_slots
);

    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int IW = $clog2(MAX_SLOTS);
    localparam logic [CW-1:0]       NULL_MARK = CW'(MAX_SLOTS);
    localparam logic [ADDR_W-1:0]   HDR_A     = ADDR_W'(HEADER_BYTES);
    localparam logic [STRIDE_W-1:0] HDR_S     = STRIDE_W'(HEADER_BYTES);

    logic [ADDR_W-1:0]   r_cfg_base;
    logic [OBJ_W-1:0]    r_cfg_obj;
    logic [REGION_W-1:0] r_cfg_region;

    logic [ADDR_W-1:0]   r_base;
    logic [STRIDE_W-1:0] r_stride;
    logic [CW-1:0]       r_head;
    logic [CW-1:0]       r_free_total;
    logic [CW-1:0]       r_slot_total;
    logic [CW-1:0]       r_walk;
    logic [ADDR_W-1:0]   r_addr;
    logic [ADDR_W-1:0]   r_prod;

    logic [CW-1:0]       n_head;
    logic [CW-1:0]       n_free_total;
    logic [CW-1:0]       n_slot_total;
    logic [CW-1:0]       n_walk;

    logic [CW-1:0]       r_link [MAX_SLOTS];
    logic [CW-1:0]       r_rd_data;
    logic                w_we;
    logic [IW-1:0]       w_wa;
    logic [CW-1:0]       w_wd;

    logic [ADDR_W-1:0]   w_diff;
    logic [ADDR_W-1:0]   w_grant;
    logic [CW-1:0]       w_walk_inc;
    logic [CW-1:0]       w_count;
    logic                w_div_start;
    logic [DIV_W-1:0]    w_dividend;
    logic [STRIDE_W-1:0] w_divisor;
    logic [STRIDE_W-1:0] w_new_stride;
    logic                w_div_done;
    logic [DIV_W-1:0]    w_quot;
    logic [STRIDE_W-1:0] w_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_base   <= '0;
            r_cfg_obj    <= OBJ_BYTES_RST;
            r_cfg_region <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_REGION_BASE:  r_cfg_base   <= i_cfg_data[ADDR_W-1:0];
                CFG_OBJECT_BYTES: r_cfg_obj    <= i_cfg_data[OBJ_W-1:0];
                CFG_REGION_BYTES: r_cfg_region <= i_cfg_data[REGION_W-1:0];
                default:          r_cfg_base   <= r_cfg_base;
            endcase
        end
    end

    assign w_new_stride = STRIDE_W'(r_cfg_obj) + HDR_S;
    assign w_diff       = r_addr - r_base;
    assign w_div_start  = i_cmd.div_free || i_cmd.div_init;
    assign w_dividend   = i_cmd.div_init ? DIV_W'(r_cfg_region) : (w_diff - HDR_A);
    assign w_divisor    = i_cmd.div_init ? w_new_stride : r_stride;

    slab_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_dividend),
        .i_divisor   (w_divisor),
        .o_done      (w_div_done),
        .o_quotient  (w_quot),
        .o_remainder (w_rem)
    );

    assign w_count    = (w_quot > DIV_W'(MAX_SLOTS)) ? NULL_MARK : w_quot[CW-1:0];
    assign w_walk_inc = r_walk + CW'(1);
    assign w_grant    = r_base + r_prod + HDR_A;

    assign o_stat.empty         = (r_free_total == '0) || (r_head >= NULL_MARK);
    assign o_stat.free_pre_bad  = (r_addr == '0) || (r_free_total >= r_slot_total)
                                  || (w_diff < HDR_A);
    assign o_stat.div_done      = w_div_done;
    assign o_stat.free_post_bad = (w_rem != '0) || (w_quot >= DIV_W'(r_slot_total));
    assign o_stat.walk_last     = (w_walk_inc >= r_slot_total);

    always_comb begin
        n_head       = r_head;
        n_free_total = r_free_total;
        n_slot_total = r_slot_total;
        n_walk       = r_walk;
        if (i_cmd.clear) begin
            n_head       = NULL_MARK;
            n_free_total = '0;
            n_slot_total = '0;
        end else if (i_cmd.pop) begin
            n_head       = r_rd_data;
            n_free_total = r_free_total - CW'(1);
        end else if (i_cmd.push) begin
            n_head       = w_quot[CW-1:0];
            n_free_total = r_free_total + CW'(1);
        end else if (i_cmd.init_set) begin
            n_head       = (w_count != '0) ? '0 : NULL_MARK;
            n_free_total = w_count;
            n_slot_total = w_count;
            n_walk       = '0;
        end else if (i_cmd.walk) begin
            n_walk = w_walk_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base       <= '0;
            r_stride     <= STRIDE_W'(OBJ_BYTES_RST) + HDR_S;
            r_head       <= NULL_MARK;
            r_free_total <= '0;
            r_slot_total <= '0;
            r_walk       <= '0;
        end else begin
            if (i_cmd.div_init) begin
                r_base   <= r_cfg_base;
                r_stride <= w_new_stride;
            end
            r_head       <= n_head;
            r_free_total <= n_free_total;
            r_slot_total <= n_slot_total;
            r_walk       <= n_walk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_addr <= i_object_address;
        end
        r_prod <= ADDR_W'(r_head) * ADDR_W'(r_stride);
    end

    assign w_we = i_cmd.push || (i_cmd.walk && (r_slot_total != '0));
    assign w_wa = i_cmd.push ? w_quot[IW-1:0] : r_walk[IW-1:0];
    assign w_wd = i_cmd.push ? r_head : (o_stat.walk_last ? NULL_MARK : w_walk_inc);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_link[w_wa] <= w_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_link[r_head[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= i_cmd.respond;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.respond) begin
            o_status          <= i_cmd.resp_status;
            o_granted_address <= i_cmd.pop ? w_grant : '0;
            o_free_slots      <= FREE_W'(n_free_total);
        end
    end

endmodule

/* hdl/slab_free_list_allocator_core.sv */
// Slab free-list allocator: top level joining sequencer and datapath
//
// Requests enter on start with i_req_type and i_object_address; one is
// taken at a clock edge where start is high and busy is low. Each request
// gives exactly one result, shown for one cycle with o_result_valid high.
// Steps per request: clear responds directly; allocate checks for an empty
//   list and then grants the head slot; free checks the address, divides
//   and pushes unless rejected; initialise divides, sets the counts and walks.
// Free and initialise go through a shared divider that yields one quotient
// bit per cycle; initialise then writes the link memory one slot per cycle.
// One request is worked on at a time; busy drops during the result cycle,
// so the next request can be taken while the last result is shown.
// Configuration writes go on i_cfg_valid with i_cfg_index and i_cfg_data;
// o_cfg_ready is always high. Write configuration while busy is low.
// Reset clears the list, the counts and the configuration to their defaults;
// link memory contents are left as they are. The receiver cannot stall.
module slab_free_list_allocator_core
    import slab_pkg::*;
#(
    parameter int MAX_SLOTS    = MAX_SLOTS_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [REQ_W-1:0]     i_req_type,
    input  logic [ADDR_W-1:0]    i_object_address,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output logic                 o_result_valid,
    output logic [STATUS_W-1:0]  o_status,
    output logic [ADDR_W-1:0]    o_granted_address,
    output logic [FREE_W-1:0]    o_free_slots
);

    t_cmd    w_cmd;
    t_stat   w_stat;
    t_status w_status;

    slab_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_busy     (busy)
    );

    slab_dp #(
        .MAX_SLOTS    (MAX_SLOTS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_object_address  (i_object_address),
        .o_result_valid    (o_result_valid),
        .o_status          (w_status),
        .o_granted_address (o_granted_address),
        .o_free_slots      (o_free_slots)
    );

    assign o_status    = w_status;
    assign o_cfg_ready = 1'b1;

endmodule

/* hdl/slab_chk.sv */
// Port-level checker for the slab allocator, bound to the top level
`include "slab_free_list_allocator_core_macros.svh"

module slab_chk
    import slab_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_result_valid,
    input logic [STATUS_W-1:0] o_status,
    input logic [ADDR_W-1:0]   o_granted_address
);

    `SLAB_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "request accepted but block not busy")
    `SLAB_ASSERT_SAME(a_result_idle, i_clk, i_rst_n, o_result_valid, !busy, "result shown while still busy")
    `SLAB_ASSERT_NEXT(a_single_result, i_clk, i_rst_n, o_result_valid, !o_result_valid, "result strobe longer than one cycle")
    `SLAB_ASSERT_SAME(a_fail_no_addr, i_clk, i_rst_n, o_result_valid && (o_status != ST_DONE), o_granted_address == '0, "failed request carries an address")

endmodule

bind slab_free_list_allocator_core slab_chk u_slab_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .o_result_valid    (o_result_valid),
    .o_status          (o_status),
    .o_granted_address (o_granted_address)
);

/* tb/tb_slab_free_list_allocator_core.sv */
// Testbench for the slab free-list allocator core: directed and random requests, scoreboarded
`timescale 1ns / 1ps

module tb_slab_free_list_allocator_core;
    import slab_pkg::*;

    localparam logic [31:0] SLOTS = MAX_SLOTS_DEF;
    localparam logic [31:0] HDR = HEADER_BYTES_DEF;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);
    localparam int RANDOM_ITEMS = 1020;
    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        t_status             status;
        logic [ADDR_W-1:0]   addr;
        logic [FREE_W-1:0]   free_slots;
    } t_outcome;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [REQ_W-1:0]     req_type;
    logic [ADDR_W-1:0]    object_address;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;
    logic                 res_valid;
    logic [STATUS_W-1:0]  res_status;
    logic [ADDR_W-1:0]    res_addr;
    logic [FREE_W-1:0]    res_free;

    // register copies and slab state
    logic [31:0] cfg_base;
    logic [15:0] cfg_obj;
    logic [23:0] cfg_region;
    logic [31:0] slab_base;
    logic [31:0] slab_stride;
    logic [31:0] head_slot;
    logic [31:0] free_cnt;
    logic [31:0] slot_cnt;
    logic [31:0] next_slot [MAX_SLOTS_DEF];

    t_outcome    awaited_outcomes [$];
    logic [31:0] held_objects [$];
    t_outcome    oldest;
    int          mismatch_cnt = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;

    slab_free_list_allocator_core u_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .start             (start),
        .busy              (busy),
        .i_req_type        (req_type),
        .i_object_address  (object_address),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_result_valid    (res_valid),
        .o_status          (res_status),
        .o_granted_address (res_addr),
        .o_free_slots      (res_free)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [31:0] slot_address(input logic [31:0] idx);
        return slab_base + idx * slab_stride + HDR;
    endfunction

    task automatic slab_predict(input t_req kind, input logic [31:0] addr,
                                output t_outcome r);
        logic [31:0] d;
        logic [31:0] off;
        logic [31:0] idx;
        logic [31:0] stride;
        logic [31:0] n;
        int i;
        r.status = ST_DONE;
        r.addr = '0;
        case (kind)
            REQ_ALLOC: begin
                if (free_cnt == 0 || head_slot >= SLOTS) begin
                    r.status = ST_NO_SLOT;
                end else begin
                    r.addr = slot_address(head_slot);
                    head_slot = next_slot[head_slot];
                    free_cnt = free_cnt - 1;
                end
            end
            REQ_FREE: begin
                d = addr - slab_base;
                off = d - HDR;
                idx = off / slab_stride;
                if (addr == 0 || free_cnt >= slot_cnt || d < HDR ||
                    off % slab_stride != 0 || idx >= slot_cnt) begin
                    r.status = ST_REJECT;
                end else begin
                    next_slot[idx] = head_slot;
                    head_slot = idx;
                    free_cnt = free_cnt + 1;
                end
            end
            REQ_INIT: begin
                stride = {16'h0, cfg_obj} + HDR;
                n = {8'h0, cfg_region} / stride;
                if (n > SLOTS) n = SLOTS;
                slab_base = cfg_base;
                slab_stride = stride;
                for (i = 0; i < n; i++) begin
                    next_slot[i] = (i + 1 < n) ? i + 1 : SLOTS;
                end
                head_slot = (n > 0) ? 32'd0 : SLOTS;
                slot_cnt = n;
                free_cnt = n;
            end
            default: begin
                head_slot = SLOTS;
                slot_cnt = 0;
                free_cnt = 0;
            end
        endcase
        r.free_slots = free_cnt[FREE_W-1:0];
    endtask

    task automatic send_request(input t_req kind, input logic [31:0] addr);
        t_outcome r;
        int gap;
        int hit;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 24);
            repeat (gap) begin
                @(negedge clk);
                start = 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        start = 1'b1;
        req_type = kind;
        object_address = addr;
        do @(posedge clk); while (busy !== 1'b0);
        slab_predict(kind, addr, r);
        awaited_outcomes.push_back(r);
        if (kind == REQ_INIT || kind == REQ_CLEAR) begin
            held_objects.delete();
        end else if (kind == REQ_ALLOC && r.status == ST_DONE) begin
            held_objects.push_back(r.addr);
        end else if (kind == REQ_FREE && r.status == ST_DONE) begin
            hit = -1;
            foreach (held_objects[k]) begin
                if (hit < 0 && held_objects[k] == addr) hit = k;
            end
            if (hit >= 0) held_objects.delete(hit);
        end
    endtask

    task automatic drain_requests();
        @(negedge clk);
        start = 1'b0;
        burst_left = 0;
        while (awaited_outcomes.size() != 0 || busy !== 1'b0) @(negedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] index, input logic [31:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data = data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        case (index)
            CFG_REGION_BASE:  cfg_base = data;
            CFG_OBJECT_BYTES: cfg_obj = data[15:0];
            CFG_REGION_BYTES: cfg_region = data[23:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_slab(input logic [31:0] base, input logic [15:0] obj,
                            input logic [23:0] region);
        drain_requests();
        write_cfg(CFG_REGION_BASE, base);
        write_cfg(CFG_OBJECT_BYTES, {16'($urandom), obj});
        write_cfg(CFG_REGION_BYTES, {8'($urandom), region});
    endtask

    task automatic test_reset_state();
        send_request(REQ_ALLOC, 32'hFFFF_FFFF);
        send_request(REQ_FREE, 32'h0000_0050);
        send_request(REQ_CLEAR, 32'hA5A5_5A5A);
    endtask

    task automatic test_alloc_exhaust();
        set_slab(32'h0000_1000, 16'd1, 24'd56);
        send_request(REQ_INIT, 32'h5A5A_A5A5);
        repeat (4) send_request(REQ_ALLOC, $urandom);
    endtask

    task automatic test_free_rejects();
        send_request(REQ_FREE, 32'h0);
        send_request(REQ_FREE, slot_address(0) + 1);
        send_request(REQ_FREE, slab_base + 5);
        send_request(REQ_FREE, slab_base - 16);
        send_request(REQ_FREE, slot_address(3));
        send_request(REQ_FREE, slot_address(1));
        send_request(REQ_FREE, slot_address(1));
        send_request(REQ_FREE, slot_address(0));
        send_request(REQ_FREE, slot_address(2));
    endtask

    task automatic test_wrap_and_latch();
        set_slab(32'hFFFF_FFF0, 16'hFFFF, 24'hFF_FFFF);
        send_request(REQ_INIT, 32'h0);
        drain_requests();
        write_cfg(CFG_REGION_BASE, 32'h0);
        write_cfg(CFG_OBJECT_BYTES, 32'd5);
        send_request(REQ_ALLOC, 32'h0);
        send_request(REQ_ALLOC, 32'hFFFF_FFFF);
        send_request(REQ_FREE, slot_address(0));
        send_request(REQ_FREE, slot_address(1));
    endtask

    task automatic test_zero_object();
        set_slab(32'h8000_0000, 16'd0, 24'hFF_FFFF);
        send_request(REQ_INIT, 32'hFFFF_FFFF);
        send_request(REQ_ALLOC, 32'h1234_5678);
        send_request(REQ_FREE, slot_address(0));
        set_slab(32'h0, 16'd64, 24'd0);
        write_cfg(CFG_SPARE, $urandom);
        send_request(REQ_INIT, 32'h0);
        send_request(REQ_ALLOC, 32'h0);
    endtask

    task automatic send_bad_free();
        logic [31:0] a;
        case ($urandom_range(0, 5))
            0: a = 32'h0;
            1: a = slot_address($urandom_range(0, (slot_cnt > 0) ? slot_cnt - 1 : 0)) +
                   $urandom_range(1, slab_stride - 1);
            2: a = slab_base + $urandom_range(0, HDR - 1);
            3: a = slot_address(slot_cnt + $urandom_range(0, 3));
            4: a = slab_base - $urandom_range(1, 4096);
            default: a = $urandom;
        endcase
        send_request(REQ_FREE, a);
    endtask

    task automatic test_random_traffic();
        int sent;
        int len;
        int pick;
        int n;
        logic [31:0] base;
        logic [15:0] obj;
        logic [31:0] stride;
        logic [31:0] region;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 3);
            base = (pick == 0) ? 32'h0 :
                   (pick == 1) ? 32'hFFFF_FFFF - $urandom_range(0, 65535) : $urandom;
            pick = $urandom_range(0, 19);
            obj = (pick == 0) ? 16'hFFFF : (pick == 1) ? 16'd1 :
                  (pick == 2) ? 16'd0 : 16'($urandom_range(1, 300));
            stride = {16'h0, obj} + HDR;
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                region = 32'hFF_FFFF;
            end else if (pick == 1) begin
                region = $urandom_range(0, stride - 1);
            end else begin
                n = (pick < 5) ? $urandom_range(25, 200) : $urandom_range(1, 24);
                region = n * stride + $urandom_range(0, stride - 1);
                if (region > 32'hFF_FFFF) region = 32'hFF_FFFF;
            end
            set_slab(base, obj, region[23:0]);
            send_request(REQ_INIT, $urandom);
            sent++;
            len = $urandom_range(30, 80);
            repeat (len) begin
                pick = $urandom_range(0, 99);
                if (pick < 40 || (pick < 75 && held_objects.size() == 0)) begin
                    send_request(REQ_ALLOC, $urandom);
                end else if (pick < 75) begin
                    send_request(REQ_FREE,
                                 held_objects[$urandom_range(0, held_objects.size() - 1)]);
                end else if (pick < 83 && slot_cnt > 0) begin
                    send_request(REQ_FREE, slot_address($urandom_range(0, slot_cnt - 1)));
                end else if (pick < 91) begin
                    send_bad_free();
                end else if (pick < 95) begin
                    send_request(REQ_CLEAR, $urandom);
                end else begin
                    send_request(REQ_INIT, $urandom);
                end
                sent++;
            end
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && res_valid === 1'b1) begin
            if (awaited_outcomes.size() == 0) begin
                if (mismatch_cnt < 10) begin
                    $display("%0t: result with no request outstanding: status %0d addr %h",
                             $realtime, res_status, res_addr);
                end
                mismatch_cnt++;
            end else begin
                oldest = awaited_outcomes.pop_front();
                if (res_status !== oldest.status || res_addr !== oldest.addr ||
                    res_free !== oldest.free_slots) begin
                    if (mismatch_cnt < 10) begin
                        $display("%0t: status %0d/%0d addr %h/%h free %0d/%0d (exp/act)",
                                 $realtime, oldest.status, res_status, oldest.addr, res_addr,
                                 oldest.free_slots, res_free);
                    end
                    mismatch_cnt++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((start && busy === 1'b0) || res_valid === 1'b1 || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        rst_n = 1'b0;
        start = 1'b0;
        req_type = REQ_ALLOC;
        object_address = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_REGION_BASE;
        cfg_data = '0;
        cfg_base = '0;
        cfg_obj = OBJ_BYTES_RST;
        cfg_region = '0;
        slab_base = '0;
        slab_stride = 32'd64 + HDR;
        head_slot = SLOTS;
        free_cnt = '0;
        slot_cnt = '0;
        foreach (next_slot[k]) next_slot[k] = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_alloc_exhaust();
        test_free_rejects();
        test_wrap_and_latch();
        test_zero_object();
        test_random_traffic();

        drain_requests();
        repeat (60) @(posedge clk);
        if (mismatch_cnt == 0 && awaited_outcomes.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
